// File: src/ewg_pkg.sv
// Shared widths, defaults, the weight unit request type and the weight table builder.
// No dependencies; every other file of the block imports this package.
package ewg_pkg;

   // payload and register widths
   localparam int REF_W          = 16;
   localparam int ERR_W          = 16;
   localparam int DIFF_W         = 18;
   localparam int SCALE_W        = 24;
   localparam int X_W            = DIFF_W + SCALE_W;
   localparam int WEIGHT_W       = 17;
   localparam int WEIGHT_FRAC    = 16;
   localparam int ROM_SHIFT      = 24;
   localparam int WIDTH_REG_W    = 11;
   localparam int HEIGHT_REG_W   = 16;
   localparam int CSR_DATA_W     = 24;
   localparam int CSR_INDEX_W    = 2;
   localparam int MIN_DIM        = 3;

   // defaults for the top-level parameters
   localparam int MAX_WIDTH_DEFAULT         = 1024;
   localparam int WEIGHT_TABLE_SIZE_DEFAULT = 256;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_FRAC);
   localparam logic [ERR_W-1:0]    ERR_MAX    = ERR_W'((1 << (ERR_W - 1)) - 1);

   // one weighting job handed to the weight unit
   typedef struct packed {
      logic                     start;
      logic [DIFF_W-1:0]        diff;
      logic signed [ERR_W-1:0]  error;
   } ewg_weight_req_type;

   // restoring long division, elaboration use only
   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // table entry idx = round(65536 * (1 - exp(-16 * idx / ts))), built from a
   // truncated series for the per-entry decay step and repeated rounding
   function automatic logic [WEIGHT_W-1:0] weight_entry(int unsigned idx, int unsigned ts);
      logic [63:0]  term;
      logic [63:0]  pos;
      logic [63:0]  neg;
      logic [63:0]  step;
      logic [63:0]  den;
      logic [63:0]  e;
      logic [127:0] e_wide;
      logic [64:0]  ent;
      term = 64'd1 << 32;
      pos  = '0;
      neg  = '0;
      for (int k = 0; k < 64; k++) begin
         if (term != '0) begin
            if ((k & 1) != 0) neg = neg + term;
            else pos = pos + term;
            den  = 64'(ts) * 64'(k + 1);
            term = div_u64(term * 64'd16, den);
         end
      end
      step = pos - neg;
      e    = 64'd1 << 32;
      for (int unsigned i = 0; i < idx; i++) begin
         e_wide = 128'(e) * 128'(step) + (128'd1 << 31);
         e      = e_wide[95:32];
      end
      ent = 65'(64'd1 << 32) - 65'(e) + 65'd32768;
      return ent[WEIGHT_FRAC +: WEIGHT_W];
   endfunction

endpackage

// File: src/ewg_line_buffer.sv
// Two-row reference line store (one packed memory word per column), the
// middle-row window, the top/bottom hold registers and the cross-difference sum.
// Depends on ewg_pkg.
module ewg_line_buffer import ewg_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic signed [REF_W-1:0] ref_value,
   input  logic                    upd_en,
   output logic [DIFF_W-1:0]       diff
);
   localparam int AW = $clog2(MAX_WIDTH);

   // word layout: upper half is the older row, lower half the newer row
   logic [2*REF_W-1:0]      mem [MAX_WIDTH];
   logic [2*REF_W-1:0]      rd_data_ff;
   logic [AW-1:0]           addr_ff;
   logic signed [REF_W-1:0] ref_ff;

   logic signed [REF_W-1:0] window_ff [3];
   logic signed [REF_W-1:0] top_hold_ff;
   logic signed [REF_W-1:0] bottom_hold_ff;

   logic signed [REF_W-1:0] mid_new;
   logic signed [REF_W-1:0] top_new;

   function automatic logic [REF_W-1:0] abs_diff(logic signed [REF_W-1:0] a,
                                                 logic signed [REF_W-1:0] b);
      logic signed [REF_W:0] d;
      d = {a[REF_W-1], a} - {b[REF_W-1], b};
      return d[REF_W] ? REF_W'(-d) : d[REF_W-1:0];
   endfunction

   assign mid_new = rd_data_ff[REF_W-1:0];
   assign top_new = rd_data_ff[2*REF_W-1:REF_W];

   // read the column, then write back the shifted pair
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         addr_ff    <= rd_addr;
         ref_ff     <= ref_value;
      end
      if (upd_en) begin
         mem[addr_ff] <= {mid_new, ref_ff};
      end
   end

   // cross sum against the window as it stands after this shift
   always_comb begin
      diff = DIFF_W'(abs_diff(window_ff[1], window_ff[2]))
           + DIFF_W'(abs_diff(mid_new, window_ff[2]))
           + DIFF_W'(abs_diff(top_hold_ff, window_ff[2]))
           + DIFF_W'(abs_diff(bottom_hold_ff, window_ff[2]));
   end

   // advance window and holds once per pixel transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff[0]   <= '0;
         window_ff[1]   <= '0;
         window_ff[2]   <= '0;
         top_hold_ff    <= '0;
         bottom_hold_ff <= '0;
      end else if (upd_en) begin
         window_ff[0]   <= window_ff[1];
         window_ff[1]   <= window_ff[2];
         window_ff[2]   <= mid_new;
         top_hold_ff    <= top_new;
         bottom_hold_ff <= ref_ff;
      end
   end

endmodule

// File: src/ewg_error_delay.sv
// Circular error delay memory of MAX_WIDTH+1 entries with its write pointer;
// reads the oldest owed entry given the owed count. Depends on ewg_pkg.
module ewg_error_delay import ewg_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [$clog2(MAX_WIDTH+2)-1:0] pending,
   input  logic                    push,
   input  logic signed [ERR_W-1:0] wr_data,
   output logic signed [ERR_W-1:0] rd_data
);
   localparam int DEPTH = MAX_WIDTH + 1;
   localparam int DW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH + 2);

   logic signed [ERR_W-1:0] mem [DEPTH];
   logic signed [ERR_W-1:0] rd_data_ff;
   logic [DW-1:0]           wr_pos_ff;
   logic [DW-1:0]           wr_pos_in;
   logic [CW:0]             wpos_ext;
   logic [CW:0]             pend_ext;
   logic [CW:0]             rd_idx_wide;
   logic [DW-1:0]           rd_idx;

   // oldest owed entry sits pending places behind the write pointer
   always_comb begin
      wpos_ext    = (CW+1)'(wr_pos_ff);
      pend_ext    = (CW+1)'(pending);
      rd_idx_wide = (wpos_ext >= pend_ext) ? wpos_ext - pend_ext
                                           : wpos_ext + (CW+1)'(DEPTH) - pend_ext;
      rd_idx      = rd_idx_wide[DW-1:0];
      wr_pos_in   = (wr_pos_ff == DW'(DEPTH - 1)) ? '0 : wr_pos_ff + 1'b1;
   end

   // read-first: a read and a write of the same entry return the old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
      if (push) begin
         mem[wr_pos_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
      end else if (push) begin
         wr_pos_ff <= wr_pos_in;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ewg_weight_unit.sv
// Five-stage weighting pipeline: scale the cross sum, index the 1-exp(-x)
// table (saturating at one), multiply the error magnitude, round and clip.
// Depends on ewg_pkg.
module ewg_weight_unit import ewg_pkg::*; #(
   parameter int WEIGHT_TABLE_SIZE = WEIGHT_TABLE_SIZE_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ewg_weight_req_type      req,
   input  logic [SCALE_W-1:0]      scale,
   output logic                    done,
   output logic signed [ERR_W-1:0] result
);
   localparam int IW     = $clog2(WEIGHT_TABLE_SIZE);
   localparam int PW     = ROM_SHIFT + $clog2(WEIGHT_TABLE_SIZE + 1);
   localparam int PROD_W = ERR_W + WEIGHT_W;
   localparam int Q_W    = PROD_W - WEIGHT_FRAC;

   logic [WEIGHT_W-1:0] rom_table [WEIGHT_TABLE_SIZE];

   logic [4:0]              valid_ff;
   logic [4:0]              valid_in;
   logic [X_W-1:0]          x_ff;
   logic [X_W-1:0]          x_in;
   logic signed [ERR_W-1:0] err1_ff;
   logic signed [ERR_W-1:0] err2_ff;
   logic                    sat_ff;
   logic                    sat_in;
   logic [PW-1:0]           iprod_ff;
   logic [PW-1:0]           iprod_in;
   logic [IW-1:0]           rom_idx;
   logic [WEIGHT_W-1:0]     weight_ff;
   logic [WEIGHT_W-1:0]     weight_in;
   logic                    neg3_ff;
   logic                    neg3_in;
   logic [ERR_W-1:0]        mag3_ff;
   logic [ERR_W-1:0]        mag3_in;
   logic                    neg4_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [PROD_W-1:0]       prod_in;
   logic [PROD_W-1:0]       rsum;
   logic [Q_W-1:0]          q;
   logic [Q_W-1:0]          q_neg;
   logic signed [ERR_W-1:0] result_ff;
   logic signed [ERR_W-1:0] result_in;

   // weight table, fixed at elaboration
   for (genvar gi = 0; gi < WEIGHT_TABLE_SIZE; gi++) begin : g_rom
      localparam logic [WEIGHT_W-1:0] ENTRY = weight_entry(gi, WEIGHT_TABLE_SIZE);
      assign rom_table[gi] = ENTRY;
   end

   always_comb begin
      valid_in  = {valid_ff[3:0], req.start};
      // stage 1: x = diff * scale
      x_in      = X_W'(req.diff) * X_W'(scale);
      // stage 2: saturate beyond the table, otherwise scale to an index
      sat_in    = |x_ff[X_W-1:ROM_SHIFT];
      iprod_in  = PW'(x_ff[ROM_SHIFT-1:0]) * PW'(WEIGHT_TABLE_SIZE);
      // stage 3: table lookup and error magnitude
      rom_idx   = iprod_ff[ROM_SHIFT +: IW];
      weight_in = sat_ff ? WEIGHT_ONE : rom_table[rom_idx];
      neg3_in   = err2_ff[ERR_W-1];
      mag3_in   = neg3_in ? ERR_W'(-err2_ff) : ERR_W'(err2_ff);
      // stage 4: magnitude times weight
      prod_in   = PROD_W'(mag3_ff) * PROD_W'(weight_ff);
      // stage 5: round half away from zero, restore sign, clip
      rsum      = prod_ff + PROD_W'(1 << (WEIGHT_FRAC - 1));
      q         = rsum[PROD_W-1:WEIGHT_FRAC];
      q_neg     = Q_W'(0) - q;
      if (neg4_ff) begin
         result_in = q_neg[ERR_W-1:0];
      end else if (q > Q_W'(ERR_MAX)) begin
         result_in = ERR_MAX;
      end else begin
         result_in = q[ERR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload stages advance with their valid bits
   always_ff @(posedge clock) begin
      if (req.start) begin
         x_ff    <= x_in;
         err1_ff <= req.error;
      end
      if (valid_ff[0]) begin
         sat_ff   <= sat_in;
         iprod_ff <= iprod_in;
         err2_ff  <= err1_ff;
      end
      if (valid_ff[1]) begin
         weight_ff <= weight_in;
         neg3_ff   <= neg3_in;
         mag3_ff   <= mag3_in;
      end
      if (valid_ff[2]) begin
         prod_ff <= prod_in;
         neg4_ff <= neg3_ff;
      end
      if (valid_ff[3]) begin
         result_ff <= result_in;
      end
   end

   assign done   = valid_ff[4];
   assign result = result_ff;

endmodule

// File: src/edge_weighted_error_gating.sv
// Sequence: a flush with a result owed goes from acceptance to the emit state; a pixel first
// reads the line store, then a filling pixel returns to idle, a border pixel goes to emit and
// an interior pixel passes the five-stage weight unit before emit. One transaction at a time: a
// new request is taken only in idle, so the emit state, held until the output is free, holds input.
// Reset clears counters, window and output valid at once; both memories are not cleared.
// Depends on ewg_pkg, ewg_line_buffer, ewg_error_delay and ewg_weight_unit.
module edge_weighted_error_gating import ewg_pkg::*; #(
   parameter int MAX_WIDTH         = MAX_WIDTH_DEFAULT,
   parameter int WEIGHT_TABLE_SIZE = WEIGHT_TABLE_SIZE_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_type,
   input  logic signed [REF_W-1:0] req_ref_value,
   input  logic signed [ERR_W-1:0] req_error_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [ERR_W-1:0] rsp_error_out,
   output logic                    rsp_last_of_frame,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 2);
   localparam int XW = (CW > WIDTH_REG_W) ? CW : WIDTH_REG_W;
   localparam int RW = HEIGHT_REG_W + 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_SCALE = CSR_INDEX_W'(2);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LINE,
      S_WEIGHT,
      S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [SCALE_W-1:0]      scale_ff, scale_in;
   logic [AW-1:0]           col_ff, col_in;
   logic [HEIGHT_REG_W-1:0] row_ff, row_in;
   logic [AW-1:0]           out_col_ff, out_col_in;
   logic [HEIGHT_REG_W-1:0] out_row_ff, out_row_in;
   logic [CW-1:0]           pending_ff, pending_in;
   logic                    emit_ff, emit_in;
   logic                    weighted_ff, weighted_in;
   logic                    last_ff, last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ERR_W-1:0] rsp_error_ff, rsp_error_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [XW-1:0]           width_x;
   logic [CW-1:0]           w_eff;
   logic [HEIGHT_REG_W-1:0] h_eff;
   logic                    accept;
   logic                    emit_now;
   logic                    interior;
   logic                    at_last;
   logic [CW-1:0]           col_inc;
   logic [RW-1:0]           row_inc;
   logic [CW-1:0]           out_col_inc;
   logic [RW-1:0]           out_row_inc;
   logic                    out_free;

   logic [DIFF_W-1:0]       line_diff;
   logic signed [ERR_W-1:0] delay_rd_data;
   ewg_weight_req_type      weight_req;
   logic                    weight_done;
   logic signed [ERR_W-1:0] weight_result;

   // effective frame size
   always_comb begin
      width_x = XW'(width_ff);
      if (width_x < XW'(MIN_DIM)) begin
         w_eff = CW'(MIN_DIM);
      end else if (width_x > XW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_x);
      end
      h_eff = (height_ff < HEIGHT_REG_W'(MIN_DIM)) ? HEIGHT_REG_W'(MIN_DIM) : height_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // position of the next result and of the next input
   always_comb begin
      emit_now    = req_type ? (pending_ff != '0) : (pending_ff >= w_eff + CW'(1));
      interior    = (out_row_ff >= HEIGHT_REG_W'(1))
                 && (RW'(out_row_ff) + RW'(2) <= RW'(h_eff))
                 && (out_col_ff >= AW'(1))
                 && (CW'(out_col_ff) + CW'(2) <= w_eff);
      at_last     = (out_row_ff == h_eff - HEIGHT_REG_W'(1))
                 && (CW'(out_col_ff) == w_eff - CW'(1));
      col_inc     = CW'(col_ff) + CW'(1);
      row_inc     = RW'(row_ff) + RW'(1);
      out_col_inc = CW'(out_col_ff) + CW'(1);
      out_row_inc = RW'(out_row_ff) + RW'(1);
      out_free    = !rsp_valid_ff || rsp_ready;
   end

   // next-state and register updates
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      scale_in     = scale_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      pending_in   = pending_ff;
      emit_in      = emit_ff;
      weighted_in  = weighted_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_error_in = rsp_error_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_REG_W-1:0];
            CSR_WEIGHT_SCALE: scale_in  = csr_wdata[SCALE_W-1:0];
            default:          ;
         endcase
      end

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               emit_in     = emit_now;
               weighted_in = !req_type && interior;
               last_in     = at_last;
               if (emit_now) begin
                  if (out_col_inc >= w_eff) begin
                     out_col_in = '0;
                     out_row_in = (out_row_inc >= RW'(h_eff)) ? '0
                                                              : out_row_inc[HEIGHT_REG_W-1:0];
                  end else begin
                     out_col_in = out_col_inc[AW-1:0];
                  end
               end
               if (req_type) begin
                  if (emit_now) begin
                     pending_in = pending_ff - CW'(1);
                     state_in   = S_EMIT;
                  end
               end else begin
                  if (!emit_now) begin
                     pending_in = pending_ff + CW'(1);
                  end
                  if (col_inc >= w_eff) begin
                     col_in = '0;
                     row_in = (row_inc >= RW'(h_eff)) ? '0 : row_inc[HEIGHT_REG_W-1:0];
                  end else begin
                     col_in = col_inc[AW-1:0];
                  end
                  state_in = S_LINE;
               end
            end
         end
         S_LINE: begin
            if (!emit_ff) begin
               state_in = S_IDLE;
            end else if (weighted_ff) begin
               state_in = S_WEIGHT;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_WEIGHT: begin
            if (weight_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_error_in = weighted_ff ? weight_result : delay_rd_data;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= WIDTH_REG_W'(1024);
         height_ff    <= HEIGHT_REG_W'(480);
         scale_ff     <= SCALE_W'(32768);
         col_ff       <= '0;
         row_ff       <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         pending_ff   <= '0;
         emit_ff      <= 1'b0;
         weighted_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         scale_ff     <= scale_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         pending_ff   <= pending_in;
         emit_ff      <= emit_in;
         weighted_ff  <= weighted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff      <= last_in;
      rsp_error_ff <= rsp_error_in;
      rsp_last_ff  <= rsp_last_in;
   end

   ewg_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept && !req_type),
      .rd_addr   (col_ff),
      .ref_value (req_ref_value),
      .upd_en    (state_ff == S_LINE),
      .diff      (line_diff)
   );

   ewg_error_delay #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_error_delay (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && emit_now),
      .pending (pending_ff),
      .push    (accept && !req_type),
      .wr_data (req_error_value),
      .rd_data (delay_rd_data)
   );

   // start a weighting job for an interior pixel once its taps are in
   always_comb begin
      weight_req.start = (state_ff == S_LINE) && emit_ff && weighted_ff;
      weight_req.diff  = line_diff;
      weight_req.error = delay_rd_data;
   end

   ewg_weight_unit #(
      .WEIGHT_TABLE_SIZE (WEIGHT_TABLE_SIZE)
   ) u_weight_unit (
      .clock  (clock),
      .reset  (reset),
      .req    (weight_req),
      .scale  (scale_ff),
      .done   (weight_done),
      .result (weight_result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_error_out     = rsp_error_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

// File: src/ewg_checker.sv
// Port-level checks for edge_weighted_error_gating, attached with a bind.
// Depends on ewg_pkg and the top level's port list.
module ewg_checker import ewg_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_type,
   input logic signed [REF_W-1:0] req_ref_value,
   input logic signed [ERR_W-1:0] req_error_value,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [ERR_W-1:0] rsp_error_out,
   input logic                    rsp_last_of_frame,
   input logic                    csr_we,
   input logic [CSR_INDEX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0]   csr_wdata
);

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_out)
                                  && $stable(rsp_last_of_frame))
      else $error("result changed while stalled");

   // reset leaves no result behind
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // reset returns the block to accepting
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("not ready after reset");

   // a pixel transaction always occupies the line store in the cycle after its acceptance
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_type |=> !req_ready)
      else $error("pixel transaction did not occupy the block");

endmodule

bind edge_weighted_error_gating ewg_checker u_ewg_checker (.*);

// File: test/tb_top.sv
// Self-checking bench for edge_weighted_error_gating: raster pixel and flush transactions in,
// weighted error pixels out, checked against a cycle-free predictor kept inside this module.
// Depends on ewg_pkg and the edge_weighted_error_gating top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ewg_pkg::*;

   localparam int MAX_W         = MAX_WIDTH_DEFAULT;
   localparam int ROM_SIZE      = WEIGHT_TABLE_SIZE_DEFAULT;
   localparam int DELAY_N       = MAX_W + 1;
   localparam int GAIN_ONE      = 1 << WEIGHT_FRAC;
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 1500;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE  = 2'd3;

   typedef struct packed {
      logic signed [ERR_W-1:0] error_out;
      logic                    last_of_frame;
   } gated_pixel_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_type = REQ_PIXEL;
   logic signed [REF_W-1:0] req_ref_value = '0;
   logic signed [ERR_W-1:0] req_error_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [ERR_W-1:0] rsp_error_out;
   logic                    rsp_last_of_frame;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // idling knobs, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // pixel content shaping
   int ref_base  = 0;
   int ref_noise = 48;

   int fault_count = 0;
   int cycle_count = 0;

   gated_pixel_t gated_due [$];

   // predictor state, mirrors the block after reset
   int unsigned gain_rom [ROM_SIZE];
   int          line_rows [2][MAX_W] = '{default: 0};
   int          err_delay [DELAY_N] = '{default: 0};
   int          tap [3] = '{default: 0};
   int          above_tap = 0;
   int          below_tap = 0;
   int unsigned col_in = 0;
   int unsigned row_in = 0;
   int unsigned owed_count = 0;
   int unsigned wr_ptr = 0;
   int unsigned col_out = 0;
   int unsigned row_out = 0;
   logic [WIDTH_REG_W-1:0]  cfg_width = 11'd1024;
   logic [HEIGHT_REG_W-1:0] cfg_height = 16'd480;
   logic [SCALE_W-1:0]      cfg_scale = 24'd32768;

   edge_weighted_error_gating uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_ref_value     (req_ref_value),
      .req_error_value   (req_error_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_error_out     (rsp_error_out),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // build the 1-exp(-x) table: series for the decay per entry, then repeated rounding
   initial begin : weight_table
      longint unsigned term, pos, neg, decay, e;
      term = 64'd1 << 32;
      pos  = 0;
      neg  = 0;
      for (int k = 0; k < 64 && term != 0; k++) begin
         if (k % 2 == 1) neg += term;
         else pos += term;
         term = (term * 64'd16) / (64'(ROM_SIZE) * 64'(k + 1));
      end
      decay = pos - neg;
      e     = 64'd1 << 32;
      for (int i = 0; i < ROM_SIZE; i++) begin
         gain_rom[i] = 32'(((64'd1 << 32) - e + 64'd32768) >> 16);
         e = (e * decay + (64'd1 << 31)) >> 32;
      end
   end

   function automatic int unsigned eff_width();
      if (cfg_width < MIN_DIM) return MIN_DIM;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height < MIN_DIM) ? MIN_DIM : cfg_height;
   endfunction

   function automatic int unsigned abs_gap(int a, int b);
      return (a > b) ? int'(a - b) : int'(b - a);
   endfunction

   // scale the tap sum, look up the weight, round the magnitude and saturate
   function automatic int weigh(int err, int unsigned diff);
      longint unsigned x, idx, mag;
      int unsigned     g;
      longint          q;
      bit              neg;
      x   = 64'(diff) * 64'(cfg_scale);
      idx = (x * 64'(ROM_SIZE)) >> ROM_SHIFT;
      g   = (idx >= ROM_SIZE) ? GAIN_ONE : gain_rom[idx];
      neg = err < 0;
      mag = 64'(neg ? -err : err) * 64'(g);
      q   = longint'((mag + 64'd32768) >> WEIGHT_FRAC);
      if (neg) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return int'(q);
   endfunction

   // queue one result and advance the output raster position
   function automatic void post_result(int v, int unsigned w, int unsigned h);
      gated_pixel_t res;
      res.error_out     = ERR_W'(v);
      res.last_of_frame = (row_out == h - 1 && col_out == w - 1);
      gated_due.push_back(res);
      col_out++;
      if (col_out >= w) begin
         col_out = 0;
         row_out++;
         if (row_out >= h) row_out = 0;
      end
   endfunction

   // advance the predictor by one accepted transaction
   function automatic void gate_item(logic kind, logic [REF_W-1:0] ref_in,
                                     logic [ERR_W-1:0] err_in);
      int unsigned w, h, c, diff, idx;
      int          r, e, mid_new, top_new, v;
      bit          interior;
      w = eff_width();
      h = eff_height();
      if (kind == REQ_FLUSH) begin
         // drain the oldest owed pixel unweighted
         if (owed_count != 0) begin
            idx = (wr_ptr + DELAY_N - owed_count) % DELAY_N;
            owed_count--;
            post_result(err_delay[idx], w, h);
         end
      end else begin
         r = $signed(ref_in);
         e = $signed(err_in);
         c = col_in % MAX_W;
         // shift the line store and the middle-row taps
         mid_new = line_rows[0][c];
         top_new = line_rows[1][c];
         line_rows[1][c] = mid_new;
         line_rows[0][c] = r;
         tap[0] = tap[1];
         tap[1] = tap[2];
         tap[2] = mid_new;
         diff = abs_gap(tap[0], tap[1]) + abs_gap(tap[2], tap[1])
              + abs_gap(above_tap, tap[1]) + abs_gap(below_tap, tap[1]);
         above_tap = top_new;
         below_tap = r;
         col_in++;
         if (col_in >= w) begin
            col_in = 0;
            row_in++;
            if (row_in >= h) row_in = 0;
         end
         if (owed_count >= w + 1) begin
            idx = (wr_ptr + DELAY_N - owed_count) % DELAY_N;
            v = err_delay[idx];
            interior = row_out >= 1 && row_out + 2 <= h && col_out >= 1 && col_out + 2 <= w;
            if (interior) v = weigh(v, diff);
            err_delay[wr_ptr] = e;
            wr_ptr = (wr_ptr + 1) % DELAY_N;
            post_result(v, w, h);
         end else begin
            owed_count++;
            err_delay[wr_ptr] = e;
            wr_ptr = (wr_ptr + 1) % DELAY_N;
         end
      end
   endfunction

   // reference pixels: mostly a smooth level with noise, sometimes a jump or an extreme
   function automatic logic [REF_W-1:0] pick_ref();
      int sel;
      int v;
      sel = $urandom_range(0, 19);
      if (sel == 0) ref_base = int'($urandom_range(0, 65535)) - 32768;
      if (sel == 1) v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      else v = ref_base + int'($urandom_range(0, 2 * ref_noise)) - ref_noise;
      return REF_W'(v);
   endfunction

   function automatic logic [ERR_W-1:0] pick_err();
      case ($urandom_range(0, 15))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return ERR_W'($urandom);
      endcase
   endfunction

   function automatic logic [SCALE_W-1:0] pick_scale();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 24'hFFFFFF;
         2:       return 24'd32768;
         default: return SCALE_W'($urandom_range(0, (1 << $urandom_range(1, 24)) - 1));
      endcase
   endfunction

   // offer one transaction, hold it until accepted, then predict
   task automatic push_item(input logic kind, input logic [REF_W-1:0] ref_in,
                            input logic [ERR_W-1:0] err_in);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_ref_value   <= ref_in;
      req_error_value <= err_in;
      do @(posedge clock); while (!req_ready);
      gate_item(kind, ref_in, err_in);
   endtask

   task automatic push_pixel();
      push_item(REQ_PIXEL, pick_ref(), pick_err());
   endtask

   task automatic push_flush();
      push_item(REQ_FLUSH, REF_W'($urandom), ERR_W'($urandom));
   endtask

   task automatic drain_all();
      while (owed_count != 0) push_flush();
   endtask

   // drop valid, wait for every expected result, then let the block go quiet
   task automatic settle(input int pad);
      req_valid <= 1'b0;
      do @(posedge clock); while (gated_due.size() != 0);
      repeat (pad) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_WIDTH:  cfg_width  = data[WIDTH_REG_W-1:0];
         REG_HEIGHT: cfg_height = data[HEIGHT_REG_W-1:0];
         REG_SCALE:  cfg_scale  = data[SCALE_W-1:0];
         default:    ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // 3x3 frames: pipeline fill, saturating centre, flush with nothing owed,
   // flush in mid-frame and a hold-off until all results are back
   task automatic test_small_frames();
      logic [REF_W-1:0] frame_ref [9] = '{16'h0000, 16'h8000, 16'h0000,
                                          16'h8000, 16'h7FFF, 16'h8000,
                                          16'h0000, 16'h8000, 16'h0000};
      logic [ERR_W-1:0] frame_err [9] = '{16'h7FFF, 16'h8000, 16'h0001,
                                          16'hFFFF, 16'h8000, 16'h0000,
                                          16'h7FFF, 16'h1234, 16'h8000};
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_reg(REG_WIDTH, 3);
      write_reg(REG_HEIGHT, 3);
      write_reg(REG_SCALE, 24'd32768);
      for (int i = 0; i < 9; i++) push_item(REQ_PIXEL, frame_ref[i], frame_err[i]);
      drain_all();
      push_flush();
      // flat reference: centre weight comes from the first table entry
      for (int i = 0; i < 5; i++) push_item(REQ_PIXEL, 16'h0064, (i == 4) ? 16'h7FFF : pick_err());
      push_flush();
      settle(0);
      for (int i = 0; i < 4; i++) push_item(REQ_PIXEL, 16'h0064, pick_err());
      drain_all();
   endtask

   // one full-width frame; also leaves every line store entry written
   task automatic test_full_width_frame();
      send_idle_pct  = 6;
      recv_stall_pct = 59;
      ref_noise      = 48;
      settle(SETTLE_CYCLES);
      write_reg(REG_WIDTH, 11'h7FF);
      write_reg(REG_HEIGHT, 0);
      write_reg(REG_SCALE, 24'd32768);
      repeat (MAX_W * MIN_DIM) push_pixel();
      drain_all();
   endtask

   // well-formed frames of random size, back to back or drained, under each idling pattern
   task automatic test_random_frames();
      int sent, w, h, n, sel;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
         endcase
         sent = 0;
         while (sent < RANDOM_ITEMS / 4) begin
            settle(SETTLE_CYCLES);
            sel = $urandom_range(0, 9);
            if (sel < 6) w = $urandom_range(3, 8);
            else if (sel < 9) w = $urandom_range(9, 40);
            else w = $urandom_range(41, 160);
            h = (w > 40) ? $urandom_range(3, 4) : $urandom_range(3, 6);
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
            write_reg(REG_SCALE, pick_scale());
            case ($urandom_range(0, 4))
               0:       ref_noise = 0;
               1:       ref_noise = 4;
               2:       ref_noise = 400;
               3:       ref_noise = 8000;
               default: ref_noise = 48;
            endcase
            n = w * h;
            repeat ($urandom_range(1, 3)) begin
               for (int k = 0; k < n; k++) begin
                  if (owed_count != 0 && $urandom_range(0, 11) == 0) begin
                     push_flush();
                     sent++;
                  end
                  if (k == n / 2 && $urandom_range(0, 3) == 0) settle(0);
                  push_pixel();
                  sent++;
               end
            end
            sent += owed_count;
            drain_all();
         end
      end
   endtask

   // register writes with pixels still owed and counters past the new bounds
   task automatic test_mid_frame_reconfig();
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      send_idle_pct  = 6;
      recv_stall_pct = 6;
      ref_noise      = 48;
      settle(SETTLE_CYCLES);
      write_reg(REG_WIDTH, 20);
      write_reg(REG_HEIGHT, 4);
      write_reg(REG_SCALE, pick_scale());
      repeat (21) push_pixel();
      // narrower row with a larger backlog: backlog is kept
      settle(SETTLE_CYCLES);
      write_reg(REG_WIDTH, 3);
      repeat (8) push_pixel();
      settle(SETTLE_CYCLES);
      write_reg(REG_WIDTH, 1);
      write_reg(REG_HEIGHT, 2);
      repeat (7) push_pixel();
      settle(SETTLE_CYCLES);
      write_reg(REG_HEIGHT, 16'hFFFF);
      write_reg(REG_WIDTH, 0);
      repeat (10) push_pixel();
      settle(SETTLE_CYCLES);
      write_reg(REG_WIDTH, 1024);
      write_reg(REG_HEIGHT, 1);
      write_reg(REG_SPARE, CSR_DATA_W'($urandom));
      repeat (12) push_pixel();
      settle(SETTLE_CYCLES);
      write_reg(REG_WIDTH, 2);
      // loose mix of random writes, pixels and flushes
      repeat (8) begin
         settle(SETTLE_CYCLES);
         idx  = $urandom_range(0, 3);
         data = (idx == REG_SCALE || $urandom_range(0, 3) == 0) ?
                CSR_DATA_W'($urandom) : CSR_DATA_W'($urandom_range(0, 12));
         write_reg(idx, data);
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 1) != 0) push_pixel();
            else push_flush();
         end
      end
      drain_all();
   endtask

   // receiver stalls
   always @(posedge clock) rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : result_check
      gated_pixel_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gated_due.size() == 0) begin
            $display("%0t: unexpected transaction, error_out %h last_of_frame %b",
                     $time, rsp_error_out, rsp_last_of_frame);
            fault_count++;
         end else begin
            want = gated_due.pop_front();
            if (rsp_error_out !== want.error_out) begin
               $display("%0t: error_out expected %h actual %h",
                        $time, want.error_out, rsp_error_out);
               fault_count++;
            end
            if (rsp_last_of_frame !== want.last_of_frame) begin
               $display("%0t: last_of_frame expected %b actual %b",
                        $time, want.last_of_frame, rsp_last_of_frame);
               fault_count++;
            end
         end
      end
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: errors");
      $finish;
   end

   initial begin : run
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_small_frames();
      test_full_width_frame();
      test_random_frames();
      test_mid_frame_reconfig();
      settle(SETTLE_CYCLES);
      if (fault_count == 0 && gated_due.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: files.f
src/ewg_pkg.sv
src/ewg_line_buffer.sv
src/ewg_error_delay.sv
src/ewg_weight_unit.sv
src/edge_weighted_error_gating.sv
src/ewg_checker.sv
test/tb_top.sv
